@@ rtl/parallel_adc_block_averager_core_defines.svh @@
// Assertion macros for the parallel ADC block averager.
// Used by the top level; relies on clk_i and rst_ni in the enclosing module.
`ifndef PARALLEL_ADC_BLOCK_AVERAGER_CORE_DEFINES_SVH
`define PARALLEL_ADC_BLOCK_AVERAGER_CORE_DEFINES_SVH

`define PAB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PAB_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/pabavg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the parallel ADC block averager.
// No dependencies.
package pabavg_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned BusW          = 16;
  localparam int unsigned SumW          = 32;
  localparam int unsigned CountW        = 17;
  localparam int unsigned AvgW          = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 17;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned DivCntW       = $clog2(SumW);
  localparam logic [CountW-1:0] BlockSizeRst = CountW'(65537);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE = 2'd0,
    CFG_BIT_ORDER  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic              read_strobe;
    logic              convert_start_n;
    logic              avg_req;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] divisor;
  } job_t;

endpackage

@@ rtl/pabavg_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts ticks, holds configuration, accumulates samples and
// queues one job per tick. Depends on pabavg_pkg.
module pabavg_front import pabavg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                busy_req_i,
  input  logic [BusW-1:0]     data_bus_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                full_i,
  output logic                push_o,
  output job_t                push_job_o
);

  logic [CountW-1:0]      block_size_q, block_size_d;
  logic                   bit_order_q, bit_order_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [CountW-1:0]      count_q, count_d;
  logic [SAMPLE_BITS-1:0] sample_raw, sample_rev, sample;
  logic [SumW-1:0]        sum_add;
  logic [CountW-1:0]      count_inc, bs_eff;
  logic                   accept, blk_done, cfg_we;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full_i;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    sample_raw = data_bus_i[SAMPLE_BITS-1:0];
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      sample_rev[i] = sample_raw[SAMPLE_BITS-1-i];
    end
    sample    = bit_order_q ? sample_rev : sample_raw;
    sum_add   = sum_q + SumW'(sample);
    count_inc = count_q + CountW'(1);
    bs_eff    = (block_size_q == '0) ? CountW'(1) : block_size_q;
    blk_done  = !busy_req_i && (count_inc >= bs_eff);
  end

  always_comb begin
    push_o                     = accept;
    push_job_o.read_strobe     = !busy_req_i;
    push_job_o.convert_start_n = busy_req_i;
    push_job_o.avg_req         = blk_done;
    push_job_o.sum             = sum_add;
    push_job_o.divisor         = bs_eff;
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (accept && !busy_req_i) begin
      if (blk_done) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_add;
        count_d = count_inc;
      end
    end
  end

  always_comb begin
    block_size_d = block_size_q;
    bit_order_d  = bit_order_q;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BLOCK_SIZE: block_size_d = cfg_data_i[CountW-1:0];
        CFG_BIT_ORDER:  bit_order_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeRst;
      bit_order_q  <= 1'b0;
      sum_q        <= '0;
      count_q      <= '0;
    end else begin
      block_size_q <= block_size_d;
      bit_order_q  <= bit_order_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
    end
  end

endmodule

@@ rtl/pabavg_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between front and back ends.
// Depends on pabavg_pkg.
module pabavg_queue import pabavg_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/pabavg_back.sv @@
`timescale 1ns / 1ps
// Back end: drains the job queue, runs the block divide one quotient bit
// per cycle and drives the output register. Depends on pabavg_pkg.
module pabavg_back import pabavg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  job_t            head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            read_strobe_o,
  output logic            convert_start_n_o,
  output logic [AvgW-1:0] average_o,
  output logic            average_valid_o
);

  back_state_e        state_q, state_d;
  logic [CountW-1:0]  rem_q, rem_d, div_q;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] step_q, step_d;
  logic               job_strobe_q, job_csn_q;
  logic               out_valid_q, out_valid_d;
  logic               out_strobe_q, out_csn_q, out_avg_valid_q;
  logic [AvgW-1:0]    out_avg_q;
  logic [CountW:0]    trial;
  logic               trial_ge, slot_free;
  logic               div_load, load_pass, load_avg;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!empty_i && head_i.avg_req) state_d = BK_DIV;
      BK_DIV:  if (step_q == DivCntW'(SumW - 1)) state_d = BK_DONE;
      BK_DONE: if (slot_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    div_load  = (state_q == BK_IDLE) && !empty_i && head_i.avg_req;
    load_pass = (state_q == BK_IDLE) && !empty_i && !head_i.avg_req && slot_free;
    load_avg  = (state_q == BK_DONE) && slot_free;
    pop_o     = div_load || load_pass;
  end

  always_comb begin
    trial    = {rem_q, quo_q[SumW-1]} - {1'b0, div_q};
    trial_ge = !trial[CountW];
    rem_d    = trial_ge ? trial[CountW-1:0] : {rem_q[CountW-2:0], quo_q[SumW-1]};
    quo_d    = {quo_q[SumW-2:0], trial_ge};
    step_d   = step_q + DivCntW'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_pass || load_avg) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      rem_q        <= '0;
      quo_q        <= head_i.sum;
      div_q        <= head_i.divisor;
      step_q       <= '0;
      job_strobe_q <= head_i.read_strobe;
      job_csn_q    <= head_i.convert_start_n;
    end else if (state_q == BK_DIV) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      step_q <= step_d;
    end
    if (load_pass) begin
      out_strobe_q    <= head_i.read_strobe;
      out_csn_q       <= head_i.convert_start_n;
      out_avg_q       <= '0;
      out_avg_valid_q <= 1'b0;
    end else if (load_avg) begin
      out_strobe_q    <= job_strobe_q;
      out_csn_q       <= job_csn_q;
      out_avg_q       <= quo_q[AvgW-1:0];
      out_avg_valid_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_strobe_o     = out_strobe_q;
  assign convert_start_n_o = out_csn_q;
  assign average_o         = out_avg_q;
  assign average_valid_o   = out_avg_valid_q;

endmodule

@@ rtl/parallel_adc_block_averager_core.sv @@
`timescale 1ns / 1ps
// Parallel ADC block averager: one result item per input tick. Ticks are
// taken one per clock into a job queue (QUEUE_DEPTH entries) while it is
// not full; a completing tick occupies the shared restoring divider, which
// yields one quotient bit per cycle, and following ticks queue behind it.
// Configuration writes are always taken and apply to the next tick.
`include "parallel_adc_block_averager_core_defines.svh"
module parallel_adc_block_averager_core import pabavg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                busy_req_i,
  input  logic [BusW-1:0]     data_bus_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                read_strobe_o,
  output logic                convert_start_n_o,
  output logic [AvgW-1:0]     average_o,
  output logic                average_valid_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic push, full, pop, empty;
  job_t push_job, head;

  pabavg_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .busy_req_i  (busy_req_i),
    .data_bus_i  (data_bus_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  pabavg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  pabavg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_strobe_o     (read_strobe_o),
    .convert_start_n_o (convert_start_n_o),
    .average_o         (average_o),
    .average_valid_o   (average_valid_o)
  );

  `PAB_ASSERT_IMPL(a_avg_read, out_valid_o && average_valid_o, read_strobe_o, "no read")
  `PAB_ASSERT_IMPL(a_strobe_cs, out_valid_o, read_strobe_o != convert_start_n_o, "cs_n clash")
  `PAB_ASSERT_IMPL(a_avg_zero, out_valid_o && !average_valid_o, average_o == '0, "stray average")

endmodule

@@ bench/parallel_adc_block_averager_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for parallel_adc_block_averager_core: ticks and results
// on valid/ready channels, checked against a block-averaging predictor.
// Depends on pabavg_pkg and the core RTL only.
module parallel_adc_block_averager_core_tb;
  import pabavg_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;
  localparam int unsigned        LongTicks   = 40;

  typedef struct packed {
    logic            busy;
    logic [BusW-1:0] bus;
  } tick_t;

  typedef struct packed {
    logic            strobe;
    logic            cs_n;
    logic [AvgW-1:0] avg;
    logic            avg_valid;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                busy_req_i = 1'b1;
  logic [BusW-1:0]     data_bus_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                read_strobe_o;
  logic                convert_start_n_o;
  logic [AvgW-1:0]     average_o;
  logic                average_valid_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state and register copies
  logic [CountW-1:0] blk_size = BlockSizeRst;
  logic              bit_rev  = 1'b0;
  logic [SumW-1:0]   run_sum  = '0;
  logic [CountW-1:0] run_cnt  = '0;

  tick_t    tick_q[$];
  outcome_t predicted_q[$];

  int unsigned n_pushed = 0;
  int unsigned n_taken = 0;
  int unsigned n_averages = 0;
  int unsigned n_writes = 0;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 79;
  logic        in_acc = 1'b0;
  logic        cfg_acc = 1'b0;

  parallel_adc_block_averager_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .busy_req_i        (busy_req_i),
    .data_bus_i        (data_bus_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_strobe_o     (read_strobe_o),
    .convert_start_n_o (convert_start_n_o),
    .average_o         (average_o),
    .average_valid_o   (average_valid_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic outcome_t accumulate_tick(logic busy, logic [BusW-1:0] bus);
    outcome_t        o;
    logic [SumW-1:0] smp;
    logic [SumW-1:0] divisor;
    logic [SumW-1:0] quo;
    o = '0;
    if (busy) begin
      o.cs_n = 1'b1;
    end else begin
      smp = '0;
      for (int i = 0; i < SampleBitsDef; i++) begin
        smp[bit_rev ? SampleBitsDef - 1 - i : i] = bus[i];
      end
      divisor = (blk_size == '0) ? 32'd1 : SumW'(blk_size);
      o.strobe = 1'b1;
      run_sum  = run_sum + smp;
      run_cnt  = run_cnt + CountW'(1);
      if (SumW'(run_cnt) >= divisor) begin
        quo         = run_sum / divisor;
        o.avg       = quo[AvgW-1:0];
        o.avg_valid = 1'b1;
        run_sum     = '0;
        run_cnt     = '0;
      end
    end
    return o;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // monitor: track handshakes, predict on accepted ticks, check results
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      in_acc  <= 1'b0;
      cfg_acc <= 1'b0;
    end else begin
      in_acc  <= in_valid_i && in_ready_o;
      cfg_acc <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        n_writes++;
        case (cfg_index_i)
          CFG_BLOCK_SIZE: blk_size = cfg_data_i[CountW-1:0];
          CFG_BIT_ORDER:  bit_rev  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        predicted_q.push_back(accumulate_tick(busy_req_i, data_bus_i));
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual avg %h valid %b",
                   $time, average_o, average_valid_o);
          errors++;
        end else begin
          want = predicted_q.pop_front();
          check_field("read_strobe", 32'(want.strobe), 32'(read_strobe_o));
          check_field("convert_start_n", 32'(want.cs_n), 32'(convert_start_n_o));
          check_field("average", 32'(want.avg), 32'(average_o));
          check_field("average_valid", 32'(want.avg_valid), 32'(average_valid_o));
          if (want.avg_valid) n_averages++;
        end
      end
    end
  end

  // tick driver: hold until accepted, then idle or present the next item
  always @(negedge clk_i) begin
    tick_t t;
    if (!in_valid_i || in_acc) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = tick_q.pop_front();
        busy_req_i <= t.busy;
        data_bus_i <= t.bus;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_tick(logic busy, logic [BusW-1:0] bus);
    tick_t t;
    t.busy = busy;
    t.bus  = bus;
    tick_q.push_back(t);
    n_pushed++;
  endtask

  task automatic settle();
    do @(negedge clk_i); while (n_taken != n_pushed || predicted_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_segment(int unsigned n);
    logic [CfgDataW-1:0] bs;
    logic [BusW-1:0]     bus;
    case ($urandom_range(9))
      0:             bs = '0;
      1:             bs = CfgDataW'(1);
      2, 3, 4, 5, 6: bs = CfgDataW'($urandom_range(8, 2));
      7, 8:          bs = CfgDataW'($urandom_range(40, 9));
      default:       bs = CfgDataW'($urandom_range(200, 41));
    endcase
    write_reg(CFG_BLOCK_SIZE, bs);
    write_reg(CFG_BIT_ORDER, CfgDataW'($urandom));
    repeat (n) begin
      case ($urandom_range(7))
        0:       bus = '0;
        1:       bus = '1;
        default: bus = BusW'($urandom);
      endcase
      push_tick($urandom_range(3) == 0, bus);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset block size holds these in the running sum
    push_tick(1'b1, 16'hFFFF);
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b1, 16'h0000);
    // shrink block size mid-block
    write_reg(CFG_BLOCK_SIZE, CfgDataW'(1));
    push_tick(1'b0, 16'h8001);
    write_reg(CFG_BIT_ORDER, CfgDataW'(1));
    push_tick(1'b0, 16'h0001);
    push_tick(1'b0, 16'h8000);
    push_tick(1'b0, 16'h00FF);
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b1, 16'h1234);
    write_reg(CFG_BLOCK_SIZE, '0);
    push_tick(1'b0, 16'hA5A5);
    push_tick(1'b1, 16'h5A5A);
    // spare indexes must leave both registers alone
    write_reg(CFG_SPARE_2, '0);
    write_reg(CFG_SPARE_3, '1);
    push_tick(1'b0, 16'h0003);
    push_tick(1'b0, 16'h0F00);
    write_reg(CFG_BLOCK_SIZE, CfgDataW'(3));
    write_reg(CFG_BIT_ORDER, CfgDataW'(0));
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b0, 16'h0001);

    for (int p = 0; p < 3; p++) begin
      settle();
      send_idle_pct = (p == 0) ? 21 : (p == 1) ? 79 : 0;
      recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 21 : 0;
      repeat (5) random_segment(50);
    end

    // largest block: build a large sum, then close the block early
    write_reg(CFG_BLOCK_SIZE, '1);
    write_reg(CFG_BIT_ORDER, CfgDataW'(0));
    repeat (LongTicks) push_tick(1'b0, 16'hFFFF);
    write_reg(CFG_BLOCK_SIZE, CfgDataW'(2));
    push_tick(1'b0, 16'hFFFF);

    settle();
    repeat (60) @(negedge clk_i);
    $display("Run covered %0d ticks, %0d block averages and %0d register writes;",
             n_taken, n_averages, n_writes);
    $display("%0d mismatches seen across three idling patterns and a long block closed early.",
             errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
